/* rtl/priority_round_robin_task_scheduler_top_defines.svh */
// ----------------------------------------------------------------------------
// scheduler assertion macros
// shared property wrappers for the scheduler checker
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH

// clocked property, masked while reset is held
`define SCHED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define SCHED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/prrts_pkg.sv */
// ----------------------------------------------------------------------------
// prrts_pkg
// shared constants and types of the task scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package prrts_pkg;

  localparam int MAX_TASKS   = 8;
  localparam int PRIO_LEVELS = 8;
  localparam int IDX_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W      = 3;
  localparam int TICK_W      = 32;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 48;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_DELAY  = 2'd2;
  localparam logic [1:0] CMD_SELECT = 2'd3;

  // result status codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  // slot states
  localparam logic [1:0] TS_EMPTY   = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;
  localparam logic [1:0] TS_BLOCKED = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic ld;     // latch the accepted item
    logic sweep;  // tick: process one slot
    logic scan;   // select: examine one slot
    logic exec;   // apply command and load result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/priority_round_robin_task_scheduler_top.sv */
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top
// fixed-priority round-robin task scheduler with a streaming command port
// ----------------------------------------------------------------------------
// One command transfer in gives exactly one result transfer out. The block
// holds an eight-slot task table; slot 0 is a ready idle task at the lowest
// priority after reset. Add and delay go from acceptance straight to execute;
// tick first runs a sweep that visits one slot per cycle to count down blocked
// delays, and select first runs a scan that examines one occupied slot per
// cycle, in rotation after the current task. A new command is accepted while
// the previous result still waits in the output register; execution stalls
// only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_round_robin_task_scheduler_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [1:0] command, [4:2] new_priority, [36:5] delay_ticks, [39:37] zero
  input  wire logic [prrts_pkg::IN_W-1:0]   in_tdata,
  // result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [1:0] status, [4:2] task_index, [5] current_valid, [8:6] current_task,
  // [40:9] tick_count, [47:41] zero
  output logic [prrts_pkg::OUT_W-1:0]       out_tdata
);

  // sequencer commands and datapath status
  prrts_pkg::dp_cmd_t  dp_cmd;
  prrts_pkg::dp_stat_t dp_stat;

  // controller: idle / sweep / scan / execute
  prrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tdata[1:0]),
    .in_ready (in_tready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  // datapath: task table, scan registers, result register
  prrts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/prrts_ctrl.sv */
// ----------------------------------------------------------------------------
// prrts_ctrl
// command sequencer: accept, slot sweep or scan, execute
// ----------------------------------------------------------------------------
`default_nettype none

module prrts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_ready,
  output prrts_pkg::dp_cmd_t     dp_cmd,
  input  wire prrts_pkg::dp_stat_t dp_stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    dp_cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        dp_cmd.ld = in_valid;
        if (in_valid) begin
          case (in_cmd)
            prrts_pkg::CMD_TICK:   state_nxt = S_SWEEP;
            prrts_pkg::CMD_SELECT: state_nxt = S_SCAN;
            default:               state_nxt = S_EXEC;
          endcase
        end
      end
      S_SWEEP: begin
        dp_cmd.sweep = 1'b1;
        if (dp_stat.sweep_last) state_nxt = S_EXEC;
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_stat.scan_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        dp_cmd.exec = dp_stat.out_free;
        if (dp_stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/prrts_dp.sv */
// ----------------------------------------------------------------------------
// prrts_dp
// task table, slot sweep and scan datapath, result register
// ----------------------------------------------------------------------------
`default_nettype none

module prrts_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [prrts_pkg::IN_W-1:0]      in_data,
  input  wire prrts_pkg::dp_cmd_t              dp_cmd,
  output prrts_pkg::dp_stat_t                  dp_stat,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [prrts_pkg::OUT_W-1:0]          out_data
);

  // task table
  logic [1:0]                     tstate_r [prrts_pkg::MAX_TASKS];
  logic [prrts_pkg::PRIO_W-1:0]   tprio_r  [prrts_pkg::MAX_TASKS];
  logic [prrts_pkg::TICK_W-1:0]   tdelay_r [prrts_pkg::MAX_TASKS];

  logic [prrts_pkg::CNT_W-1:0]    tcount_r;
  logic [prrts_pkg::IDX_W-1:0]    cur_r;
  logic                           present_r;
  logic [prrts_pkg::TICK_W-1:0]   ticks_r;

  // latched item
  logic [1:0]                     cmd_r;
  logic [prrts_pkg::PRIO_W-1:0]   prio_r;
  logic [prrts_pkg::TICK_W-1:0]   dly_r;

  // sweep / scan
  logic [prrts_pkg::IDX_W-1:0]    cnt_r;
  logic [prrts_pkg::IDX_W-1:0]    pos_r;
  logic                           found_r;
  logic [prrts_pkg::PRIO_W-1:0]   best_r;
  logic [prrts_pkg::IDX_W-1:0]    chosen_r;

  // result register
  logic                           out_valid_r;
  logic [prrts_pkg::OUT_W-1:0]    out_data_r;

  // execute-stage values
  logic [1:0]                     res_status;
  logic [prrts_pkg::IDX_W-1:0]    res_idx;
  logic [prrts_pkg::IDX_W-1:0]    cur_nxt;
  logic                           present_nxt;
  logic [prrts_pkg::TICK_W-1:0]   ticks_nxt;
  logic [prrts_pkg::IDX_W-1:0]    sel_idx;
  logic                           add_full;
  logic [prrts_pkg::PRIO_W-1:0]   add_prio;
  logic                           scan_take;
  logic [prrts_pkg::CNT_W-1:0]    tcount_m1;

  // rotation successor, wrapping at the occupied count
  function automatic logic [prrts_pkg::IDX_W-1:0] next_slot(
    input logic [prrts_pkg::IDX_W-1:0] p,
    input logic [prrts_pkg::CNT_W-1:0] cnt
  );
    logic [prrts_pkg::CNT_W-1:0] p1;
    p1 = {1'b0, p} + prrts_pkg::CNT_W'(1);
    return (p1 >= cnt) ? '0 : p1[prrts_pkg::IDX_W-1:0];
  endfunction

  assign tcount_m1 = tcount_r - prrts_pkg::CNT_W'(1);
  assign dp_stat.sweep_last = (cnt_r == prrts_pkg::IDX_W'(prrts_pkg::MAX_TASKS - 1));
  assign dp_stat.scan_last  = ({1'b0, cnt_r} == tcount_m1);
  assign dp_stat.out_free   = !out_valid_r || out_ready;

  assign scan_take = ((tstate_r[pos_r] == prrts_pkg::TS_READY) ||
                      (tstate_r[pos_r] == prrts_pkg::TS_RUNNING)) &&
                     (!found_r || (tprio_r[pos_r] < best_r));

  assign add_full = (tcount_r >= prrts_pkg::CNT_W'(prrts_pkg::MAX_TASKS));
  assign add_prio = ({1'b0, prio_r} >= (prrts_pkg::PRIO_W + 1)'(prrts_pkg::PRIO_LEVELS)) ?
                    prrts_pkg::PRIO_W'(prrts_pkg::PRIO_LEVELS - 1) : prio_r;
  assign sel_idx  = found_r ? chosen_r : '0;

  always_comb begin
    res_status  = prrts_pkg::STS_DONE;
    res_idx     = '0;
    cur_nxt     = cur_r;
    present_nxt = present_r;
    ticks_nxt   = ticks_r;
    case (cmd_r)
      prrts_pkg::CMD_ADD: begin
        if (add_full) res_status = prrts_pkg::STS_FULL;
        else          res_idx    = tcount_r[prrts_pkg::IDX_W-1:0];
      end
      prrts_pkg::CMD_TICK: begin
        ticks_nxt = ticks_r + prrts_pkg::TICK_W'(1);
      end
      prrts_pkg::CMD_DELAY: begin
        if (dly_r == '0 || !present_r) res_status = prrts_pkg::STS_IGNORED;
      end
      prrts_pkg::CMD_SELECT: begin
        res_idx     = sel_idx;
        cur_nxt     = sel_idx;
        present_nxt = 1'b1;
      end
      default: res_status = prrts_pkg::STS_DONE;
    endcase
  end

  // table and scalar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < prrts_pkg::MAX_TASKS; i++) begin
        tstate_r[i] <= prrts_pkg::TS_EMPTY;
        tprio_r[i]  <= '0;
      end
      tstate_r[0] <= prrts_pkg::TS_READY;
      tprio_r[0]  <= prrts_pkg::PRIO_W'(prrts_pkg::PRIO_LEVELS - 1);
      tcount_r    <= prrts_pkg::CNT_W'(1);
      cur_r       <= '0;
      present_r   <= 1'b0;
      ticks_r     <= '0;
    end else begin
      if (dp_cmd.sweep) begin
        if (tstate_r[cnt_r] == prrts_pkg::TS_BLOCKED && tdelay_r[cnt_r] != '0) begin
          tdelay_r[cnt_r] <= tdelay_r[cnt_r] - prrts_pkg::TICK_W'(1);
          if (tdelay_r[cnt_r] == prrts_pkg::TICK_W'(1)) begin
            tstate_r[cnt_r] <= prrts_pkg::TS_READY;
          end
        end
      end
      if (dp_cmd.exec) begin
        cur_r     <= cur_nxt;
        present_r <= present_nxt;
        ticks_r   <= ticks_nxt;
        case (cmd_r)
          prrts_pkg::CMD_ADD: begin
            if (!add_full) begin
              tstate_r[tcount_r[prrts_pkg::IDX_W-1:0]] <= prrts_pkg::TS_READY;
              tprio_r[tcount_r[prrts_pkg::IDX_W-1:0]]  <= add_prio;
              tdelay_r[tcount_r[prrts_pkg::IDX_W-1:0]] <= '0;
              tcount_r <= tcount_r + prrts_pkg::CNT_W'(1);
            end
          end
          prrts_pkg::CMD_DELAY: begin
            if (dly_r != '0 && present_r) begin
              tstate_r[cur_r] <= prrts_pkg::TS_BLOCKED;
              tdelay_r[cur_r] <= dly_r;
            end
          end
          prrts_pkg::CMD_SELECT: begin
            // old running task goes back to ready unless it is picked again
            if (present_r && cur_r != sel_idx &&
                tstate_r[cur_r] == prrts_pkg::TS_RUNNING) begin
              tstate_r[cur_r] <= prrts_pkg::TS_READY;
            end
            tstate_r[sel_idx] <= prrts_pkg::TS_RUNNING;
          end
          default: ;
        endcase
      end
    end
  end

  // item latch and sweep / scan registers
  always_ff @(posedge clk) begin
    if (dp_cmd.ld) begin
      cmd_r   <= in_data[1:0];
      prio_r  <= in_data[4:2];
      dly_r   <= in_data[36:5];
      cnt_r   <= '0;
      pos_r   <= next_slot(cur_r, tcount_r);
      found_r <= 1'b0;
    end else if (dp_cmd.sweep) begin
      cnt_r <= cnt_r + prrts_pkg::IDX_W'(1);
    end else if (dp_cmd.scan) begin
      cnt_r <= cnt_r + prrts_pkg::IDX_W'(1);
      pos_r <= next_slot(pos_r, tcount_r);
      if (scan_take) begin
        found_r  <= 1'b1;
        best_r   <= tprio_r[pos_r];
        chosen_r <= pos_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      out_data_r <= {7'd0, ticks_nxt, cur_nxt, present_nxt, res_idx, res_status};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/prrts_chk.sv */
// ----------------------------------------------------------------------------
// prrts_chk
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_round_robin_task_scheduler_top_defines.svh"

module prrts_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [prrts_pkg::IN_W-1:0]  in_tdata,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [prrts_pkg::OUT_W-1:0] out_tdata
);

  // a stalled result stays offered
  `SCHED_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // one command at a time: busy right after a transfer in
  `SCHED_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted back to back")

  // no current task means current index still at reset value
  `SCHED_ASSERT(a_cur_idle, out_tvalid && !out_tdata[5] |-> out_tdata[8:6] == 3'd0, "current index set without current task")

  // a refused add reports slot zero; checked only while reset is released
  `SCHED_ASSERT_ALWAYS(a_full_idx, rst_n && out_tvalid && out_tdata[1:0] == prrts_pkg::STS_FULL |-> out_tdata[4:2] == 3'd0, "full add reported a slot")

endmodule

bind priority_round_robin_task_scheduler_top prrts_chk u_prrts_chk (.*);

`default_nettype wire
